/* rtl/pcr_pkg.sv */
// shared types, constants and sample decode functions of the pcm converter
package pcr_pkg;

  // defaults of the top-level parameters
  localparam int MAX_CHANNELS_DEF    = 8;
  localparam int PHASE_FRAC_BITS_DEF = 16;

  // output frames one input item can cause at most
  localparam int RESULT_CAP = 6;

  // queue depths
  localparam int CMD_Q_DEPTH = 2;
  localparam int OUT_Q_DEPTH = 4;

  // configuration register indexes
  localparam logic [1:0] REG_SAMPLE_WIDTH = 2'd0;
  localparam logic [1:0] REG_FLOAT        = 2'd1;
  localparam logic [1:0] REG_CHANNELS     = 2'd2;
  localparam logic [1:0] REG_STEP         = 2'd3;

  // sample width codes
  localparam logic [1:0] WC_8  = 2'd0;
  localparam logic [1:0] WC_16 = 2'd1;
  localparam logic [1:0] WC_24 = 2'd2;
  localparam logic [1:0] WC_32 = 2'd3;

  // what a request does in the back end
  typedef enum logic [1:0] {
    OP_NONE,
    OP_FRAME,
    OP_END
  } cmd_op_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_OUT
  } bk_state_t;

  // decoded request from front to back
  typedef struct packed {
    logic              restart;
    cmd_op_t           op;
    logic              bypass;
    logic signed [15:0] left;
    logic signed [15:0] right;
  } cmd_t;

  // one output frame
  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               last_of_run;
  } out_t;

  // ieee single to s16: times 32767, clipped, truncated toward zero
  function automatic logic signed [15:0] pcr_float_to_s16(input logic [31:0] u);
    logic               neg;
    logic [7:0]         ex;
    logic [23:0]        man;
    logic [38:0]        mag;
    logic [38:0]        shf;
    logic [7:0]         sh;
    logic signed [15:0] res;
    neg = u[31];
    ex  = u[30:23];
    man = (ex == 8'd0) ? {1'b0, u[22:0]} : {1'b1, u[22:0]};
    // man * 32767 as a shift and a subtract
    mag = ({15'd0, man} << 15) - {15'd0, man};
    sh  = (ex == 8'd0) ? 8'd149 : (8'd150 - ex);
    shf = (sh > 8'd38) ? '0 : (mag >> sh[5:0]);
    if (ex == 8'hff) begin
      // nan gives zero, infinities saturate
      if (u[22:0] != 23'd0) res = 16'sd0;
      else res = neg ? 16'sh8000 : 16'sh7fff;
    end else if (ex >= 8'd150) begin
      res = neg ? 16'sh8000 : 16'sh7fff;
    end else if (neg) begin
      res = (shf > 39'd32768) ? 16'sh8000 : $signed(~shf[15:0] + 16'd1);
    end else begin
      res = (shf > 39'd32767) ? 16'sh7fff : $signed(shf[15:0]);
    end
    return res;
  endfunction

  // gathered little-endian sample word to s16
  function automatic logic signed [15:0] pcr_decode(input logic [31:0] g,
                                                    input logic [1:0]  wcode,
                                                    input logic        flt);
    logic signed [15:0] res;
    unique case (wcode)
      WC_8:    res = $signed({~g[7], g[6:0], 8'h00});
      WC_16:   res = $signed(g[15:0]);
      WC_24:   res = $signed(g[23:8]);
      default: res = flt ? pcr_float_to_s16(g) : $signed(g[31:16]);
    endcase
    return res;
  endfunction

endpackage

/* rtl/pcr_fifo.sv */
// small register fifo used between the stages
module pcr_fifo
  import pcr_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

/* rtl/pcr_front.sv */
// front end: byte assembly into frames, sample decode, request issue
module pcr_front
  import pcr_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_data,
  input  logic       in_restart,
  input  logic [1:0] sample_width_code,
  input  logic       float_samples,
  input  logic [3:0] channel_count,
  input  logic       bypass,
  output logic       q_push,
  output cmd_t       q_data,
  input  logic       q_full
);

  localparam int POS_W = $clog2(4 * MAX_CHANNELS);
  localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
  localparam int LEN_W = POS_W + 1;

  // request as captured, decoded on its way into the queue
  typedef struct packed {
    logic        restart;
    cmd_op_t     op;
    logic        bypass;
    logic        mono;
    logic [1:0]  wcode;
    logic        flt;
    logic [31:0] lraw;
    logic [31:0] rraw;
  } raw_cmd_t;

  logic [POS_W-1:0] pos_r, pos_nxt, pos_c;
  logic [31:0]      lg_r, lg_nxt, lg_c;
  logic [31:0]      rg_r, rg_nxt, rg_c;
  logic             cmd_valid_r, cmd_valid_nxt;
  raw_cmd_t         cmd_r, cmd_nxt;

  logic             accept, issue, done, in_c0, in_c1, mono;
  logic [CH_W-1:0]  chn;
  logic [LEN_W-1:0] wx, posx, kdiff, flen;
  logic [1:0]       k;
  logic [31:0]      bsh, lg_new, rg_new;

  assign in_full = cmd_valid_r && q_full;
  assign accept  = in_push && !in_full;
  assign q_push  = cmd_valid_r && !q_full;

  // decode on the way into the queue
  always_comb begin
    q_data.restart = cmd_r.restart;
    q_data.op      = cmd_r.op;
    q_data.bypass  = cmd_r.bypass;
    q_data.left    = pcr_decode(cmd_r.lraw, cmd_r.wcode, cmd_r.flt);
    q_data.right   = cmd_r.mono ? q_data.left : pcr_decode(cmd_r.rraw, cmd_r.wcode, cmd_r.flt);
  end

  // frame geometry and byte placement
  always_comb begin
    pos_c = in_restart ? '0 : pos_r;
    lg_c  = in_restart ? '0 : lg_r;
    rg_c  = in_restart ? '0 : rg_r;
    if (channel_count == 4'd0) chn = CH_W'(1);
    else if (32'(channel_count) > 32'(MAX_CHANNELS)) chn = CH_W'(MAX_CHANNELS);
    else chn = CH_W'(channel_count);
    mono  = (chn == CH_W'(1));
    wx    = LEN_W'({1'b0, sample_width_code}) + LEN_W'(1);
    flen  = LEN_W'(wx * LEN_W'(chn));
    posx  = LEN_W'(pos_c);
    in_c0 = posx < wx;
    in_c1 = posx < (wx << 1);
    kdiff = posx - wx;
    k     = in_c0 ? posx[1:0] : kdiff[1:0];
    bsh   = {24'd0, in_data_byte} << {k, 3'b000};
    lg_new = in_c0 ? (lg_c | bsh) : lg_c;
    rg_new = (!in_c0 && in_c1) ? (rg_c | bsh) : rg_c;
    done  = (posx + LEN_W'(1)) >= flen;
    issue = in_restart || in_end_of_data || done;
  end

  // next assembly state and request capture
  always_comb begin
    pos_nxt       = pos_r;
    lg_nxt        = lg_r;
    rg_nxt        = rg_r;
    cmd_nxt       = cmd_r;
    cmd_valid_nxt = q_push ? 1'b0 : cmd_valid_r;
    if (accept) begin
      cmd_nxt.restart = in_restart;
      cmd_nxt.bypass  = bypass;
      cmd_nxt.mono    = mono;
      cmd_nxt.wcode   = sample_width_code;
      cmd_nxt.flt     = float_samples;
      cmd_nxt.lraw    = lg_new;
      cmd_nxt.rraw    = rg_new;
      if (in_end_of_data) begin
        pos_nxt     = '0;
        lg_nxt      = '0;
        rg_nxt      = '0;
        cmd_nxt.op  = OP_END;
      end else if (done) begin
        pos_nxt     = '0;
        lg_nxt      = '0;
        rg_nxt      = '0;
        cmd_nxt.op  = OP_FRAME;
      end else begin
        pos_nxt     = pos_c + 1'b1;
        lg_nxt      = lg_new;
        rg_nxt      = rg_new;
        cmd_nxt.op  = OP_NONE;
      end
      if (issue) cmd_valid_nxt = 1'b1;
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      lg_r        <= '0;
      rg_r        <= '0;
      cmd_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      lg_r        <= lg_nxt;
      rg_r        <= rg_nxt;
      cmd_valid_r <= cmd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

/* rtl/pcr_back.sv */
// back end: frame pair, phase accumulator and interpolation sequencer
module pcr_back
  import pcr_pkg::*;
#(
  parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [PHASE_FRAC_BITS+2:0] step_ratio,
  input  logic                       q_empty,
  input  cmd_t                       q_data,
  output logic                       q_pop,
  input  logic                       out_full,
  output logic                       out_push,
  output out_t                       out_data
);

  localparam int PF     = PHASE_FRAC_BITS;
  localparam int PH_W   = PF + 4;
  localparam int ST_W   = PF + 3;
  localparam int PROD_W = PF + 18;
  localparam int NUM_W  = PF + 19;
  localparam int CNT_W  = $clog2(RESULT_CAP + 1);
  localparam int MIN_STEP_I = ((1 << PF) + 5) / 6;
  localparam logic [PH_W-1:0] PH_ONE   = PH_W'(1) << PF;
  localparam logic [ST_W-1:0] MIN_STEP = ST_W'(MIN_STEP_I);
  localparam logic [1:0] PR_NONE = 2'd0;
  localparam logic [1:0] PR_ONE  = 2'd1;
  localparam logic [1:0] PR_PAIR = 2'd2;

  bk_state_t state_r, state_nxt;
  logic signed [15:0] el_r, el_nxt, er_r, er_nxt;
  logic signed [15:0] ll_r, ll_nxt, lr_r, lr_nxt;
  logic [PH_W-1:0]    phase_r, phase_nxt;
  logic [1:0]         primed_r, primed_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic signed [PROD_W-1:0] prod_l_r, prod_l_nxt, prod_r_r, prod_r_nxt;

  logic               bypass_frame, start_run, run_done, last;
  logic signed [15:0] el_c, er_c, ll_c, lr_c;
  logic [PH_W-1:0]    phase_c, phase_add;
  logic [1:0]         primed_c;
  logic [ST_W-1:0]    step_eff;
  logic signed [16:0] d_l, d_r;
  logic signed [PF:0] t_s;
  logic signed [15:0] y_l, y_r;

  // exact (a << pf) + prod, divided by one with truncation toward zero
  function automatic logic signed [15:0] lerp_out(input logic signed [15:0] a,
                                                  input logic signed [PROD_W-1:0] p);
    logic signed [NUM_W-1:0] num;
    logic signed [NUM_W-1:0] q;
    logic                    adj;
    num = $signed({{3{a[15]}}, a, {PF{1'b0}}}) + $signed({p[PROD_W-1], p});
    q   = num >>> PF;
    adj = num[NUM_W-1] && (num[PF-1:0] != '0);
    return $signed(q[15:0] + {15'd0, adj});
  endfunction

  assign step_eff  = (step_ratio < MIN_STEP) ? MIN_STEP : step_ratio;
  assign phase_add = phase_r + PH_W'(step_eff);
  assign run_done  = (phase_r >= PH_ONE) || (cnt_r == CNT_W'(RESULT_CAP));
  assign last      = (phase_add >= PH_ONE) || (cnt_r + 1'b1 == CNT_W'(RESULT_CAP));
  assign bypass_frame = (q_data.op == OP_FRAME) && q_data.bypass;
  assign q_pop = (state_r == BK_IDLE) && !q_empty && !(bypass_frame && out_full);

  // interpolation operands
  assign d_l = $signed({ll_r[15], ll_r}) - $signed({el_r[15], el_r});
  assign d_r = $signed({lr_r[15], lr_r}) - $signed({er_r[15], er_r});
  assign t_s = $signed({1'b0, phase_r[PF-1:0]});
  assign y_l = lerp_out(el_r, prod_l_r);
  assign y_r = lerp_out(er_r, prod_r_r);

  // request handling: restart first, then the operation
  always_comb begin
    el_c     = q_data.restart ? '0 : el_r;
    er_c     = q_data.restart ? '0 : er_r;
    ll_c     = q_data.restart ? '0 : ll_r;
    lr_c     = q_data.restart ? '0 : lr_r;
    phase_c  = q_data.restart ? '0 : phase_r;
    primed_c = q_data.restart ? PR_NONE : primed_r;
    start_run = 1'b0;
    if (!q_data.bypass) begin
      if (q_data.op == OP_FRAME) begin
        priority case (primed_c)
          PR_NONE: begin
            el_c     = q_data.left;
            er_c     = q_data.right;
            primed_c = PR_ONE;
          end
          PR_ONE: begin
            ll_c      = q_data.left;
            lr_c      = q_data.right;
            primed_c  = PR_PAIR;
            start_run = 1'b1;
          end
          default: begin
            el_c      = ll_c;
            er_c      = lr_c;
            ll_c      = q_data.left;
            lr_c      = q_data.right;
            if (phase_c >= PH_ONE) phase_c = phase_c - PH_ONE;
            start_run = 1'b1;
          end
        endcase
      end else if (q_data.op == OP_END && primed_c == PR_ONE) begin
        ll_c      = el_c;
        lr_c      = er_c;
        primed_c  = PR_PAIR;
        start_run = 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (q_pop && start_run) state_nxt = BK_MUL;
      BK_MUL:  state_nxt = run_done ? BK_IDLE : BK_OUT;
      BK_OUT: begin
        if (!out_full) state_nxt = last ? BK_IDLE : BK_MUL;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    el_nxt     = el_r;
    er_nxt     = er_r;
    ll_nxt     = ll_r;
    lr_nxt     = lr_r;
    phase_nxt  = phase_r;
    primed_nxt = primed_r;
    cnt_nxt    = cnt_r;
    prod_l_nxt = prod_l_r;
    prod_r_nxt = prod_r_r;
    out_push   = 1'b0;
    out_data.left_sample  = y_l;
    out_data.right_sample = y_r;
    out_data.last_of_run  = last;
    unique case (state_r)
      BK_IDLE: begin
        if (q_pop) begin
          el_nxt     = el_c;
          er_nxt     = er_c;
          ll_nxt     = ll_c;
          lr_nxt     = lr_c;
          phase_nxt  = phase_c;
          primed_nxt = primed_c;
          cnt_nxt    = '0;
          if (bypass_frame) begin
            out_push              = 1'b1;
            out_data.left_sample  = q_data.left;
            out_data.right_sample = q_data.right;
            out_data.last_of_run  = 1'b1;
          end
        end
      end
      BK_MUL: begin
        prod_l_nxt = PROD_W'(d_l * t_s);
        prod_r_nxt = PROD_W'(d_r * t_s);
      end
      BK_OUT: begin
        if (!out_full) begin
          out_push  = 1'b1;
          phase_nxt = phase_add;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      el_r     <= '0;
      er_r     <= '0;
      ll_r     <= '0;
      lr_r     <= '0;
      phase_r  <= '0;
      primed_r <= PR_NONE;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      el_r     <= el_nxt;
      er_r     <= er_nxt;
      ll_r     <= ll_nxt;
      lr_r     <= lr_nxt;
      phase_r  <= phase_nxt;
      primed_r <= primed_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // product registers
  always_ff @(posedge clk) begin
    prod_l_r <= prod_l_nxt;
    prod_r_r <= prod_r_nxt;
  end

`ifndef SYNTHESIS
  a_run_needs_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != BK_IDLE) |-> (primed_r == PR_PAIR))
    else $error("interpolation running without a full frame pair");
  a_run_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(RESULT_CAP))
    else $error("run produced more frames than the cap");
  a_out_phase_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_OUT) |-> (phase_r < PH_ONE))
    else $error("output stage reached with phase at or above one");
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_OUT && out_push && out_data.last_of_run) |=> (state_r == BK_IDLE))
    else $error("run continued after its last frame");
`endif

endmodule

/* rtl/pcm_convert_linear_resampler.sv */
// top level: configuration registers, front end, request queue, back end, result queue
//
// PCM to signed 16-bit stereo converter with linear-interpolation resampling.
// Raw little-endian sample bytes are pushed in one per cycle while in_full is
// low; the front end assembles frames of up to MAX_CHANNELS channels, keeps
// the first two (mono is repeated on both sides) and decodes 8/16/24/32-bit
// integer or float32 samples. Each completed frame, end marker or restart
// travels through a two-entry request queue to the back end. With step_ratio
// equal to one the frame is pushed to the result queue as it is popped.
// Otherwise the back end interpolates between the earlier and later frame at
// the unsigned 4.16 phase: each output frame passes through BK_MUL (the pair of
// multipliers) and BK_OUT (the add, truncation and phase update), and a request
// gives at most six frames; a run whose phase is already past the pair goes
// from BK_MUL straight back to idle. A full result queue stalls the back end
// in BK_OUT. Results wait in a four-entry queue; pop them while empty is low.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wdata; the user
// must do so only while no request is in flight, the block does not enforce it.
module pcm_convert_linear_resampler
  import pcr_pkg::*;
#(
  parameter int MAX_CHANNELS    = MAX_CHANNELS_DEF,
  parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [7:0]                 in_data_byte,
  input  logic                       in_end_of_data,
  input  logic                       in_restart,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic signed [15:0]         out_left_sample,
  output logic signed [15:0]         out_right_sample,
  output logic                       out_last_of_run,
  input  logic                       cfg_wr_en,
  input  logic [1:0]                 cfg_index,
  input  logic [PHASE_FRAC_BITS+2:0] cfg_wdata
);

  localparam int ST_W = PHASE_FRAC_BITS + 3;
  localparam logic [ST_W-1:0] STEP_ONE = ST_W'(1) << PHASE_FRAC_BITS;

  logic [1:0]      width_code_r;
  logic            float_r;
  logic [3:0]      channels_r;
  logic [ST_W-1:0] step_r;

  logic  cq_push, cq_full, cq_pop, cq_empty;
  cmd_t  cq_wdata, cq_rdata;
  logic  oq_push, oq_full;
  out_t  oq_wdata, oq_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_code_r <= WC_16;
      float_r      <= 1'b0;
      channels_r   <= 4'd2;
      step_r       <= STEP_ONE;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SAMPLE_WIDTH: width_code_r <= cfg_wdata[1:0];
        REG_FLOAT:        float_r      <= cfg_wdata[0];
        REG_CHANNELS:     channels_r   <= cfg_wdata[3:0];
        REG_STEP:         step_r       <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  // byte assembly and decode
  pcr_front #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_data_byte      (in_data_byte),
    .in_end_of_data    (in_end_of_data),
    .in_restart        (in_restart),
    .sample_width_code (width_code_r),
    .float_samples     (float_r),
    .channel_count     (channels_r),
    .bypass            (step_r == STEP_ONE),
    .q_push            (cq_push),
    .q_data            (cq_wdata),
    .q_full            (cq_full)
  );

  // request queue
  pcr_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cq_push),
    .wdata (cq_wdata),
    .full  (cq_full),
    .pop   (cq_pop),
    .rdata (cq_rdata),
    .empty (cq_empty)
  );

  // resampler
  pcr_back #(
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_ratio (step_r),
    .q_empty    (cq_empty),
    .q_data     (cq_rdata),
    .q_pop      (cq_pop),
    .out_full   (oq_full),
    .out_push   (oq_push),
    .out_data   (oq_wdata)
  );

  // result queue
  pcr_fifo #(
    .WIDTH ($bits(out_t)),
    .DEPTH (OUT_Q_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (oq_wdata),
    .full  (oq_full),
    .pop   (out_pop),
    .rdata (oq_rdata),
    .empty (out_empty)
  );

  assign out_left_sample  = oq_rdata.left_sample;
  assign out_right_sample = oq_rdata.right_sample;
  assign out_last_of_run  = oq_rdata.last_of_run;

endmodule

/* dv/pcm_convert_linear_resampler_checker.sv */
// checker for the pcm resampler: watches both channels, predicts output frames and compares them
`timescale 1ns / 100ps

module pcm_convert_linear_resampler_checker
  import pcr_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  input  logic                           in_full,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_end_of_data,
  input  logic                           in_restart,
  input  logic                           out_empty,
  input  logic                           out_pop,
  input  logic signed [15:0]             out_left_sample,
  input  logic signed [15:0]             out_right_sample,
  input  logic                           out_last_of_run,
  input  logic                           cfg_wr_en,
  input  logic [1:0]                     cfg_index,
  input  logic [PHASE_FRAC_BITS_DEF+2:0] cfg_wdata,
  output int                             mismatch_count,
  output int                             frames_pending,
  output int                             frames_checked
);

  // phase of one whole input frame and the smallest step that keeps a run within the cap
  localparam int unsigned PHASE_ONE  = 1 << PHASE_FRAC_BITS_DEF;
  localparam int unsigned STEP_FLOOR = (PHASE_ONE + RESULT_CAP - 1) / RESULT_CAP;
  localparam int          CFG_W      = PHASE_FRAC_BITS_DEF + 3;

  // register copies
  logic [1:0]                     width_code;
  logic                           use_float;
  logic [3:0]                     chan_reg;
  logic [PHASE_FRAC_BITS_DEF+2:0] step_reg;

  // frame assembly and resampler state
  int unsigned byte_pos;
  logic [31:0] left_acc;
  logic [31:0] right_acc;
  logic [31:0] older_frame;
  logic [31:0] newer_frame;
  int unsigned phase;
  int unsigned primed;

  // frames of the current request, and frames still owed by the block
  out_t run_frames[$];
  out_t frames_due[$];

  // ieee single times 32767, clipped, truncated toward zero
  function automatic logic signed [15:0] float_to_pcm16(input logic [31:0] u);
    int                 expo;
    int                 shift;
    longint unsigned    mant;
    longint unsigned    scaled;
    expo = u[30:23];
    mant = u[22:0];
    if (expo == 255) begin
      // nan gives silence, infinities saturate
      if (u[22:0] != 23'd0) return 16'h0000;
      return u[31] ? 16'h8000 : 16'h7fff;
    end
    if (expo == 0) begin
      shift = 149;
    end else begin
      mant = mant | (64'd1 << 23);
      shift = 150 - expo;
    end
    scaled = mant * 64'd32767;
    if (shift <= 0) return u[31] ? 16'h8000 : 16'h7fff;
    scaled = (shift >= 64) ? 64'd0 : (scaled >> shift);
    if (u[31]) return (scaled > 64'd32768) ? 16'h8000 : -scaled[15:0];
    return (scaled > 64'd32767) ? 16'h7fff : scaled[15:0];
  endfunction

  // gathered little-endian sample to s16 under the current width setting
  function automatic logic signed [15:0] sample_to_pcm16(input logic [31:0] g);
    case (width_code)
      WC_8:    return 16'((int'(g[7:0]) - 128) * 256);
      WC_16:   return g[15:0];
      WC_24:   return g[23:8];
      default: return use_float ? float_to_pcm16(g) : g[31:16];
    endcase
  endfunction

  // exact blend of two samples at phase t, truncated toward zero
  function automatic logic signed [15:0] blend(input logic signed [15:0] a,
                                               input logic signed [15:0] b,
                                               input int unsigned        t);
    longint num;
    longint q;
    num = longint'(a) * longint'(PHASE_ONE - t) + longint'(b) * longint'(t);
    q = num / longint'(PHASE_ONE);
    if (q < -32768) q = -32768;
    if (q > 32767) q = 32767;
    return q[15:0];
  endfunction

  // output frames while the phase stays inside the current pair and the run is below the cap
  task automatic interpolate_run();
    int unsigned stride;
    out_t        f;
    stride = (step_reg < STEP_FLOOR) ? STEP_FLOOR : step_reg;
    while (phase < PHASE_ONE && run_frames.size() < RESULT_CAP) begin
      f.left_sample  = blend(older_frame[15:0], newer_frame[15:0], phase);
      f.right_sample = blend(older_frame[31:16], newer_frame[31:16], phase);
      f.last_of_run  = 1'b0;
      run_frames.push_back(f);
      phase = phase + stride;
    end
  endtask

  // effect of one accepted request on the state, frames go to run_frames
  task automatic predict_request(input logic [7:0] b, input logic end_flag,
                                 input logic restart_flag);
    logic               passthrough;
    int unsigned        wbytes;
    int unsigned        chans;
    int unsigned        slot;
    int unsigned        lane;
    logic signed [15:0] l;
    logic signed [15:0] r;
    out_t               f;
    passthrough = (step_reg == PHASE_ONE);
    run_frames.delete();
    if (restart_flag) begin
      byte_pos = 0;
      left_acc = '0;
      right_acc = '0;
      older_frame = '0;
      newer_frame = '0;
      phase = 0;
      primed = 0;
    end
    if (end_flag) begin
      // partial frame is dropped, a lone primed frame is paired with itself outside passthrough
      byte_pos = 0;
      left_acc = '0;
      right_acc = '0;
      if (!passthrough && primed == 1) begin
        newer_frame = older_frame;
        primed = 2;
        interpolate_run();
      end
    end else begin
      wbytes = width_code + 1;
      chans = (chan_reg == 0) ? 1 : (chan_reg > MAX_CHANNELS_DEF) ? MAX_CHANNELS_DEF : chan_reg;
      slot = byte_pos / wbytes;
      lane = byte_pos % wbytes;
      if (slot == 0) left_acc = left_acc | (32'(b) << (8 * lane));
      else if (slot == 1) right_acc = right_acc | (32'(b) << (8 * lane));
      if (byte_pos + 1 >= wbytes * chans) begin
        l = sample_to_pcm16(left_acc);
        r = (chans == 1) ? l : sample_to_pcm16(right_acc);
        byte_pos = 0;
        left_acc = '0;
        right_acc = '0;
        if (passthrough) begin
          f.left_sample  = l;
          f.right_sample = r;
          f.last_of_run  = 1'b0;
          run_frames.push_back(f);
        end else if (primed == 0) begin
          older_frame = {r, l};
          primed = 1;
        end else if (primed == 1) begin
          newer_frame = {r, l};
          primed = 2;
          interpolate_run();
        end else begin
          older_frame = newer_frame;
          newer_frame = {r, l};
          if (phase >= PHASE_ONE) phase = phase - PHASE_ONE;
          interpolate_run();
        end
      end else begin
        byte_pos = byte_pos + 1;
      end
    end
    // the final frame of the run carries the last flag
    foreach (run_frames[i]) begin
      f = run_frames[i];
      f.last_of_run = (i == run_frames.size() - 1);
      frames_due.push_back(f);
    end
  endtask

  task automatic check_field(input string name, input logic signed [16:0] want,
                             input logic signed [16:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // sample both channels and the register port at every edge
  always @(posedge clk) begin
    out_t due;
    if (!rst_n) begin
      width_code  = WC_16;
      use_float   = 1'b0;
      chan_reg    = 4'd2;
      step_reg    = CFG_W'(PHASE_ONE);
      byte_pos    = 0;
      left_acc    = '0;
      right_acc   = '0;
      older_frame = '0;
      newer_frame = '0;
      phase       = 0;
      primed      = 0;
      frames_due.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SAMPLE_WIDTH: width_code = cfg_wdata[1:0];
          REG_FLOAT:        use_float  = cfg_wdata[0];
          REG_CHANNELS:     chan_reg   = cfg_wdata[3:0];
          REG_STEP:         step_reg   = cfg_wdata;
        endcase
      end
      // compare before predicting so a stray frame is never matched to a fresh request
      if (out_pop && !out_empty) begin
        if (frames_due.size() == 0) begin
          $error("unexpected output frame: left %0d, right %0d", out_left_sample,
                 out_right_sample);
          mismatch_count++;
        end else begin
          due = frames_due.pop_front();
          frames_checked++;
          check_field("left_sample", due.left_sample, out_left_sample);
          check_field("right_sample", due.right_sample, out_right_sample);
          check_field("last_of_run", due.last_of_run, out_last_of_run);
        end
      end
      if (in_push && !in_full) predict_request(in_data_byte, in_end_of_data, in_restart);
    end
    frames_pending = frames_due.size();
  end

endmodule

/* dv/pcm_convert_linear_resampler_tb.sv */
// testbench top for the pcm resampler: clock, reset, request and pop traffic, verdict
`timescale 1ns / 100ps

module pcm_convert_linear_resampler_tb;
  import pcr_pkg::*;

  localparam int ITEM_GOAL   = 320;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int CFG_W       = PHASE_FRAC_BITS_DEF + 3;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_push = 1'b0;
  logic [7:0]                     in_data_byte = 8'd0;
  logic                           in_end_of_data = 1'b0;
  logic                           in_restart = 1'b0;
  logic                           out_pop = 1'b0;
  logic                           cfg_wr_en = 1'b0;
  logic [1:0]                     cfg_index = REG_SAMPLE_WIDTH;
  logic [PHASE_FRAC_BITS_DEF+2:0] cfg_wdata = '0;
  logic                           in_full;
  logic                           out_empty;
  logic signed [15:0]             out_left_sample;
  logic signed [15:0]             out_right_sample;
  logic                           out_last_of_run;

  int mismatch_count;
  int frames_pending;
  int frames_checked;

  // settings the stimulus currently builds frames for
  logic [1:0]                     cur_width = WC_16;
  logic                           cur_float = 1'b0;
  logic [3:0]                     cur_chans = 4'd2;
  logic [PHASE_FRAC_BITS_DEF+2:0] cur_step  = CFG_W'(1 << PHASE_FRAC_BITS_DEF);

  int requests_sent = 0;
  int settings_used = 0;
  int pops_done = 0;
  int cycle_count = 0;
  bit flood_on = 1'b0;
  bit hold_wanted = 1'b0;
  bit hold_done = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  pcm_convert_linear_resampler dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_data_byte     (in_data_byte),
    .in_end_of_data   (in_end_of_data),
    .in_restart       (in_restart),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_left_sample  (out_left_sample),
    .out_right_sample (out_right_sample),
    .out_last_of_run  (out_last_of_run),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  pcm_convert_linear_resampler_checker frame_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_data_byte     (in_data_byte),
    .in_end_of_data   (in_end_of_data),
    .in_restart       (in_restart),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_left_sample  (out_left_sample),
    .out_right_sample (out_right_sample),
    .out_last_of_run  (out_last_of_run),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .mismatch_count   (mismatch_count),
    .frames_pending   (frames_pending),
    .frames_checked   (frames_checked)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("pcm_convert_linear_resampler_tb failed");
      $finish;
    end
  end

  function automatic int frame_channels();
    if (cur_chans == 0) return 1;
    if (cur_chans > MAX_CHANNELS_DEF) return MAX_CHANNELS_DEF;
    return int'(cur_chans);
  endfunction

  // one request; push stays high when the next one follows without a gap
  task automatic send_request(input logic [7:0] b, input logic eod, input logic rst);
    int gap;
    gap = (flood_on || (requests_sent / 24) % 4 == 3) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push        <= 1'b1;
    in_data_byte   <= b;
    in_end_of_data <= eod;
    in_restart     <= rst;
    do @(negedge clk); while (in_full);
    @(posedge clk);
    requests_sent++;
  endtask

  // one sample, low byte first
  task automatic send_word(input logic [31:0] word, input int nbytes, input logic rst_first);
    int k;
    for (k = 0; k < nbytes; k++) send_request(word[8*k +: 8], 1'b0, rst_first && k == 0);
  endtask

  // register writes only once every owed frame is out and the back end has settled
  task automatic write_settings(input logic [1:0] wc, input logic flt, input logic [3:0] ch,
                                input logic [PHASE_FRAC_BITS_DEF+2:0] step);
    in_push <= 1'b0;
    do @(negedge clk); while (frames_pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_SAMPLE_WIDTH;
    cfg_wdata <= CFG_W'(wc);
    @(posedge clk);
    cfg_index <= REG_FLOAT;
    cfg_wdata <= CFG_W'(flt);
    @(posedge clk);
    cfg_index <= REG_CHANNELS;
    cfg_wdata <= CFG_W'(ch);
    @(posedge clk);
    cfg_index <= REG_STEP;
    cfg_wdata <= step;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_width = wc;
    cur_float = flt;
    cur_chans = ch;
    cur_step  = step;
    settings_used++;
  endtask

  // integer sample with a bias toward the extremes of the width
  function automatic logic [31:0] int_pick(input int wbytes);
    case ($urandom_range(0, 7))
      0:       return 32'h80 << (8 * (wbytes - 1));
      1:       return ~(32'h80 << (8 * (wbytes - 1)));
      2:       return 32'h0;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // float sample: specials, boundaries and values near full scale
  function automatic logic [31:0] float_pick();
    logic [31:0] word;
    word = $urandom();
    case ($urandom_range(0, 15))
      0:  word = 32'h7f80_0000;
      1:  word = 32'hff80_0000;
      2:  word = 32'h7fc0_0001;
      3:  word = 32'hffa5_a5a5;
      4:  word = 32'h3f80_0000;
      5:  word = 32'hbf80_0000;
      6:  word = 32'h0000_0001;
      7:  word = 32'h807f_ffff;
      8:  word = 32'h4700_0000;
      9:  word = 32'h0000_0000;
      10: word = 32'h8000_0000;
      11: ;
      default: word[30:23] = 8'($urandom_range(110, 130));
    endcase
    return word;
  endfunction

  // a complete frame under the current settings
  task automatic send_frame(input logic rst_first);
    int          c;
    int          wbytes;
    logic [31:0] word;
    wbytes = cur_width + 1;
    for (c = 0; c < frame_channels(); c++) begin
      word = (cur_width == WC_32 && cur_float) ? float_pick() : int_pick(wbytes);
      send_word(word, wbytes, rst_first && c == 0);
    end
  endtask

  // settings for one random stretch; the first few are the corners
  task automatic pick_settings(input int stretch_no);
    int                             r;
    logic [1:0]                     wc;
    logic [3:0]                     ch;
    logic [PHASE_FRAC_BITS_DEF+2:0] step;
    case (stretch_no)
      0: write_settings(WC_32, 1'b0, 4'd15, 19'd262144);
      1: write_settings(WC_8, 1'b1, 4'd1, 19'd10923);
      2: write_settings(WC_24, 1'b0, 4'd9, 19'd65535);
      3: write_settings(WC_32, 1'b1, 4'd2, 19'd65537);
      4: write_settings(WC_16, 1'b0, 4'd0, 19'd524287);
      default: begin
        wc = 2'($urandom_range(0, 3));
        r = $urandom_range(0, 9);
        ch = (r < 6) ? 4'(1 + r % 2) : 4'($urandom_range(0, 15));
        case ($urandom_range(0, 7))
          0:       step = CFG_W'(1 << PHASE_FRAC_BITS_DEF);
          1:       step = CFG_W'($urandom_range(0, 10922));
          2:       step = CFG_W'($urandom_range(262145, 524287));
          3:       step = 19'd10923;
          4:       step = 19'd262144;
          default: step = CFG_W'($urandom_range(10923, 262144));
        endcase
        write_settings(wc, 1'($urandom_range(0, 1)), ch, step);
      end
    endcase
  endtask

  // mostly whole frames, with ends, restarts and stray bytes mixed in
  task automatic random_stretch();
    int frames;
    int pick;
    frames = ((cur_width + 1) * frame_channels() > 8) ? $urandom_range(2, 4)
                                                       : $urandom_range(2, 12);
    repeat (frames) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) send_request(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      else if (pick == 1) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      else if (pick == 2) send_request(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      else send_frame(pick == 3);
    end
    // close with an end marker, or leave a partial frame across the next register change
    case ($urandom_range(0, 3))
      0: send_request(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      1: repeat ($urandom_range(1, 3)) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      default: ;
    endcase
  endtask

  // result side: random pop gaps, one long hold-off during the flood
  initial begin
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_wanted && !hold_done) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        gap = ((pops_done / 25) % 3 == 1) ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
          out_pop <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_pop <= 1'b1;
      do @(negedge clk); while (out_empty);
      @(posedge clk);
      pops_done++;
    end
  end

  // request side
  initial begin
    int stretch_no;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, bypass: full-scale stereo frame, restart mid-frame, end drops partial
    send_word(32'h7fff_8000, 4, 1'b0);
    send_request(8'h55, 1'b0, 1'b0);
    send_request(8'haa, 1'b0, 1'b1);
    send_request(8'h3c, 1'b1, 1'b0);

    // float flag on 8-bit mono, step below range: end flushes a lone frame, repeated end
    write_settings(WC_8, 1'b1, 4'd0, 19'd1);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'h5a, 1'b1, 1'b0);
    send_request(8'hc3, 1'b1, 1'b0);
    send_request(8'hff, 1'b0, 1'b0);

    // float32, zero channels, step of 4.0: infinities and nan
    write_settings(WC_32, 1'b1, 4'd0, 19'd262144);
    send_word(32'h7f80_0000, 4, 1'b0);
    send_word(32'h7fc0_0000, 4, 1'b0);
    send_word(32'hff80_0000, 4, 1'b0);

    // back-to-back bypass bytes while the result side holds off
    write_settings(WC_8, 1'b0, 4'd1, CFG_W'(1 << PHASE_FRAC_BITS_DEF));
    flood_on = 1'b1;
    hold_wanted = 1'b1;
    repeat (48) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    flood_on = 1'b0;

    stretch_no = 0;
    while (requests_sent < ITEM_GOAL) begin
      pick_settings(stretch_no);
      random_stretch();
      stretch_no++;
    end

    // drain
    in_push <= 1'b0;
    do @(negedge clk); while (frames_pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d requests under %0d register settings, %0d output frames checked",
             requests_sent, settings_used, frames_checked);
    $display("including a %0d-cycle result hold-off with the input side backed up",
             HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("pcm_convert_linear_resampler_tb passed");
    end else begin
      $display("pcm_convert_linear_resampler_tb failed");
    end
    $finish;
  end

endmodule

/* pcm_convert_linear_resampler.f */
rtl/pcr_pkg.sv
rtl/pcr_fifo.sv
rtl/pcr_front.sv
rtl/pcr_back.sv
rtl/pcm_convert_linear_resampler.sv
dv/pcm_convert_linear_resampler_checker.sv
dv/pcm_convert_linear_resampler_tb.sv
